// ----- rtl/core/dwmo_pkg.sv -----
// ----------------------------------------------------------------------------
// dwmo_pkg
// Shared types, constants and helper functions for the dual wavetable
// morphing oscillator.
// ----------------------------------------------------------------------------
package dwmo_pkg;

    // Field and table geometry
    localparam int OPCODE_W     = 2;
    localparam int SAMPLE_W     = 16;
    localparam int PHASE_W      = 32;
    localparam int SHAPE_W      = 3;
    localparam int BLEND_W      = 8;
    localparam int INDEX_W      = 9;
    localparam int TABLE_ADDR_W = SHAPE_W + INDEX_W;
    localparam int TABLE_DEPTH  = 1 << TABLE_ADDR_W;
    localparam int WAVE_LENGTH  = 1 << INDEX_W;
    localparam int WAVE_COUNT   = 8;
    localparam int INDEX_LSB    = 16;
    localparam int CFG_INDEX_W  = 1;

    // Reset values
    localparam logic [PHASE_W-1:0] TUNE_RESET  = 32'h0001_0000;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 8'hFF;

    // Highest waveform that may be selected as the first of a crossfade pair
    localparam logic [BLEND_W-1:0] SHAPE_LIMIT = BLEND_W'(WAVE_COUNT - 2);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TUNING_ONE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TUNING_TWO = 1'b1;

    // Item opcodes; the fourth code is ignored
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK        = 2'd0,
        OP_SET_WAVE    = 2'd1,
        OP_TABLE_WRITE = 2'd2
    } opcode_t;

    // Table read request of one voice, with the blend that goes with it
    typedef struct packed {
        logic [TABLE_ADDR_W-1:0] addr_a;
        logic [TABLE_ADDR_W-1:0] addr_b;
        logic [BLEND_W-1:0]      blend;
    } voice_req_t;

    // Table write transfer held in the request stage
    typedef struct packed {
        logic                    valid;
        logic [TABLE_ADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0]     data;
    } table_wr_t;

    // Saturate a waveform index to the last pair start
    function automatic logic [SHAPE_W-1:0] shape_sat(input logic [BLEND_W-1:0] hi);
        logic [BLEND_W-1:0] lim;
        lim = (hi > SHAPE_LIMIT) ? SHAPE_LIMIT : hi;
        return lim[SHAPE_W-1:0];
    endfunction

    // out = bits 8..23 of (A-B)*blend, plus B, modulo 2^16
    function automatic logic [SAMPLE_W-1:0] crossfade(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [BLEND_W-1:0]  blend
    );
        logic signed [SAMPLE_W:0]         diff;
        logic signed [BLEND_W:0]          mix;
        logic signed [SAMPLE_W+BLEND_W+1:0] prod;
        logic [SAMPLE_W-1:0]              mid;
        diff = signed'({1'b0, a}) - signed'({1'b0, b});
        mix  = signed'({1'b0, blend});
        prod = (SAMPLE_W+BLEND_W+2)'(diff) * (SAMPLE_W+BLEND_W+2)'(mix);
        mid  = prod[SAMPLE_W+BLEND_W-1:BLEND_W];
        return mid + b;
    endfunction

endpackage

// ----- rtl/core/dwmo_ram.sv -----
// ----------------------------------------------------------------------------
// dwmo_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module dwmo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- rtl/core/dwmo_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwmo_ctrl
// Item decode, oscillator state (phase, shape, blend, pending values),
// tuning registers and the request stage that drives the table RAMs.
// ----------------------------------------------------------------------------
module dwmo_ctrl
    import dwmo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [PHASE_W-1:0]      cfg_data,
    // item channel
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [OPCODE_W-1:0]     opcode,
    input  logic                    osc_select,
    input  logic [SAMPLE_W-1:0]     wave_value,
    input  logic [TABLE_ADDR_W-1:0] table_address,
    input  logic [SAMPLE_W-1:0]     table_data,
    // request stage toward RAMs and mixer
    input  logic                    mix_ready,
    output logic                    req_tick,
    output voice_req_t              req_one,
    output voice_req_t              req_two,
    output table_wr_t               table_wr
);

    logic [PHASE_W-1:0]  tuning_one_reg, tuning_two_reg;
    logic [PHASE_W-1:0]  phase_one_reg, phase_one_next;
    logic [PHASE_W-1:0]  phase_two_reg, phase_two_next;
    logic [SHAPE_W-1:0]  shape_one_reg, shape_one_next;
    logic [SHAPE_W-1:0]  shape_two_reg, shape_two_next;
    logic [BLEND_W-1:0]  blend_one_reg, blend_one_next;
    logic [BLEND_W-1:0]  blend_two_reg, blend_two_next;
    logic [SAMPLE_W-1:0] pend_one_reg, pend_one_next;
    logic [SAMPLE_W-1:0] pend_two_reg, pend_two_next;
    logic                flag_one_reg, flag_one_next;
    logic                flag_two_reg, flag_two_next;

    logic                tick_reg;
    logic                wr_valid_reg;
    logic [TABLE_ADDR_W-1:0] wr_addr_reg;
    logic [SAMPLE_W-1:0] wr_data_reg;
    voice_req_t          req_one_reg, req_one_next;
    voice_req_t          req_two_reg, req_two_next;

    logic                stage_move;
    logic                accept;
    logic                is_tick, is_set, is_write;
    logic [INDEX_W-1:0]  idx_one, idx_two;

    // Request stage frees up when it holds no tick or the mixer takes it
    assign stage_move = !tick_reg || mix_ready;
    assign item_ready = stage_move;
    assign accept     = item_valid && item_ready;

    // Decode
    always_comb
    begin
        is_tick  = 1'b0;
        is_set   = 1'b0;
        is_write = 1'b0;
        case (opcode_t'(opcode))
            OP_TICK:        is_tick  = accept;
            OP_SET_WAVE:    is_set   = accept;
            OP_TABLE_WRITE: is_write = accept;
            default:        ;
        endcase
    end

    // Phase advance and read addresses for the two voices
    assign phase_one_next = is_tick ? phase_one_reg + tuning_one_reg : phase_one_reg;
    assign phase_two_next = is_tick ? phase_two_reg + tuning_two_reg : phase_two_reg;
    assign idx_one = phase_one_next[INDEX_LSB+INDEX_W-1:INDEX_LSB];
    assign idx_two = phase_two_next[INDEX_LSB+INDEX_W-1:INDEX_LSB];

    always_comb
    begin
        req_one_next.addr_a = {shape_one_reg, idx_one};
        req_one_next.addr_b = {shape_one_reg + SHAPE_W'(1), idx_one};
        req_one_next.blend  = blend_one_reg;
        req_two_next.addr_a = {shape_two_reg, idx_two};
        req_two_next.addr_b = {shape_two_reg + SHAPE_W'(1), idx_two};
        req_two_next.blend  = blend_two_reg;
    end

    // Pending values: queued by set-wave, one applied after each tick
    always_comb
    begin
        shape_one_next = shape_one_reg;
        shape_two_next = shape_two_reg;
        blend_one_next = blend_one_reg;
        blend_two_next = blend_two_reg;
        pend_one_next  = pend_one_reg;
        pend_two_next  = pend_two_reg;
        flag_one_next  = flag_one_reg;
        flag_two_next  = flag_two_reg;
        if (is_tick)
        begin
            if (flag_one_reg)
            begin
                shape_one_next = shape_sat(pend_one_reg[SAMPLE_W-1:BLEND_W]);
                blend_one_next = ~pend_one_reg[BLEND_W-1:0];
                flag_one_next  = 1'b0;
            end
            else if (flag_two_reg)
            begin
                shape_two_next = shape_sat(pend_two_reg[SAMPLE_W-1:BLEND_W]);
                blend_two_next = ~pend_two_reg[BLEND_W-1:0];
                flag_two_next  = 1'b0;
            end
        end
        else if (is_set)
        begin
            if (!osc_select)
            begin
                if (pend_one_reg != wave_value)
                begin
                    pend_one_next = wave_value;
                    flag_one_next = 1'b1;
                end
            end
            else if (pend_two_reg != wave_value)
            begin
                pend_two_next = wave_value;
                flag_two_next = 1'b1;
            end
        end
    end

    // Oscillator state and tuning registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_one_reg <= TUNE_RESET;
            tuning_two_reg <= TUNE_RESET;
            phase_one_reg  <= '0;
            phase_two_reg  <= '0;
            shape_one_reg  <= '0;
            shape_two_reg  <= '0;
            blend_one_reg  <= BLEND_RESET;
            blend_two_reg  <= BLEND_RESET;
            pend_one_reg   <= '0;
            pend_two_reg   <= '0;
            flag_one_reg   <= 1'b0;
            flag_two_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TUNING_ONE)
            begin
                tuning_one_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_TUNING_TWO)
            begin
                tuning_two_reg <= cfg_data;
            end
            phase_one_reg <= phase_one_next;
            phase_two_reg <= phase_two_next;
            shape_one_reg <= shape_one_next;
            shape_two_reg <= shape_two_next;
            blend_one_reg <= blend_one_next;
            blend_two_reg <= blend_two_next;
            pend_one_reg  <= pend_one_next;
            pend_two_reg  <= pend_two_next;
            flag_one_reg  <= flag_one_next;
            flag_two_reg  <= flag_two_next;
        end
    end

    // Request stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else if (stage_move)
        begin
            tick_reg     <= is_tick;
            wr_valid_reg <= is_write;
        end
    end

    // Request stage payload
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            req_one_reg <= req_one_next;
            req_two_reg <= req_two_next;
        end
        if (is_write)
        begin
            wr_addr_reg <= table_address;
            wr_data_reg <= table_data;
        end
    end

    assign req_tick       = tick_reg;
    assign req_one        = req_one_reg;
    assign req_two        = req_two_reg;
    assign table_wr.valid = wr_valid_reg;
    assign table_wr.addr  = wr_addr_reg;
    assign table_wr.data  = wr_data_reg;

endmodule

// ----- rtl/core/dwmo_mix.sv -----
// ----------------------------------------------------------------------------
// dwmo_mix
// Crossfade of the two table samples per voice and the result register.
// ----------------------------------------------------------------------------
module dwmo_mix
    import dwmo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // from request stage
    input  logic                req_tick,
    input  logic [BLEND_W-1:0]  req_blend_one,
    input  logic [BLEND_W-1:0]  req_blend_two,
    output logic                mix_ready,
    // registered table data
    input  logic [SAMPLE_W-1:0] a_one,
    input  logic [SAMPLE_W-1:0] b_one,
    input  logic [SAMPLE_W-1:0] a_two,
    input  logic [SAMPLE_W-1:0] b_two,
    // result channel
    output logic                result_valid,
    input  logic                result_ready,
    output logic [SAMPLE_W-1:0] sample_one,
    output logic [SAMPLE_W-1:0] sample_two
);

    logic                data_valid_reg;
    logic [BLEND_W-1:0]  blend_one_reg, blend_two_reg;
    logic                res_valid_reg;
    logic [SAMPLE_W-1:0] sample_one_reg, sample_one_next;
    logic [SAMPLE_W-1:0] sample_two_reg, sample_two_next;
    logic                res_load;
    logic                data_load;

    // Stage handshakes: the result register loads when empty or being drained
    assign res_load  = data_valid_reg && (!res_valid_reg || result_ready);
    assign mix_ready = !data_valid_reg || res_load;
    assign data_load = req_tick && mix_ready;

    // Crossfade
    assign sample_one_next = crossfade(a_one, b_one, blend_one_reg);
    assign sample_two_next = crossfade(a_two, b_two, blend_two_reg);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mix_ready)
            begin
                data_valid_reg <= req_tick;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (data_load)
        begin
            blend_one_reg <= req_blend_one;
            blend_two_reg <= req_blend_two;
        end
        if (res_load)
        begin
            sample_one_reg <= sample_one_next;
            sample_two_reg <= sample_two_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign sample_one   = sample_one_reg;
    assign sample_two   = sample_two_reg;

endmodule

// ----- rtl/core/dual_wavetable_morph_oscillator_top.sv -----
// ----------------------------------------------------------------------------
// dual_wavetable_morph_oscillator_top
// Two DDS oscillators reading a shared wave table, each crossfading two
// adjacent waveforms.
// ----------------------------------------------------------------------------
// The block takes one item per clock while item_ready is high; a tick held
// by a stalled result side holds it low. A tick returns both voices' samples
// through the request register that addresses the table, the table's
// registered read, then the crossfade into the result register. The four
// reads of a tick come from two copies of the 4096-word table (one per
// voice, two read ports each); table writes go to both copies. Set-wave and
// table-write items return nothing. The table is not cleared after reset:
// load every word a tick can reach before the first tick. Tuning words must
// be written only while no tick is in flight; the block does not enforce it.
module dual_wavetable_morph_oscillator_top
    import dwmo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [PHASE_W-1:0]      cfg_data,
    // item channel
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [OPCODE_W-1:0]     opcode,
    input  logic                    osc_select,
    input  logic [SAMPLE_W-1:0]     wave_value,
    input  logic [TABLE_ADDR_W-1:0] table_address,
    input  logic [SAMPLE_W-1:0]     table_data,
    // result channel
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [SAMPLE_W-1:0]     sample_one,
    output logic [SAMPLE_W-1:0]     sample_two
);

    logic                req_tick;
    logic                mix_ready;
    logic                rd_en;
    voice_req_t          req_one, req_two;
    table_wr_t           table_wr;
    logic [SAMPLE_W-1:0] a_one, b_one, a_two, b_two;

    // Table read fires when the mixer takes the tick
    assign rd_en = req_tick && mix_ready;

    // Decode, oscillator state and request stage
    dwmo_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .osc_select    (osc_select),
        .wave_value    (wave_value),
        .table_address (table_address),
        .table_data    (table_data),
        .mix_ready     (mix_ready),
        .req_tick      (req_tick),
        .req_one       (req_one),
        .req_two       (req_two),
        .table_wr      (table_wr)
    );

    // Table copy for voice one
    dwmo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table_one (
        .clk     (clk),
        .we      (table_wr.valid),
        .waddr   (table_wr.addr),
        .wdata   (table_wr.data),
        .re      (rd_en),
        .raddr_a (req_one.addr_a),
        .raddr_b (req_one.addr_b),
        .rdata_a (a_one),
        .rdata_b (b_one)
    );

    // Table copy for voice two
    dwmo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table_two (
        .clk     (clk),
        .we      (table_wr.valid),
        .waddr   (table_wr.addr),
        .wdata   (table_wr.data),
        .re      (rd_en),
        .raddr_a (req_two.addr_a),
        .raddr_b (req_two.addr_b),
        .rdata_a (a_two),
        .rdata_b (b_two)
    );

    // Crossfade and result register
    dwmo_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_tick      (req_tick),
        .req_blend_one (req_one.blend),
        .req_blend_two (req_two.blend),
        .mix_ready     (mix_ready),
        .a_one         (a_one),
        .b_one         (b_one),
        .a_two         (a_two),
        .b_two         (b_two),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .sample_one    (sample_one),
        .sample_two    (sample_two)
    );

endmodule

// ----- rtl/core/dwmo_checker.sv -----
// ----------------------------------------------------------------------------
// dwmo_checker
// Port-level checks for the oscillator top level, bound to every instance.
// ----------------------------------------------------------------------------
module dwmo_checker
    import dwmo_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic [OPCODE_W-1:0]     opcode,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [SAMPLE_W-1:0]     sample_one,
    input logic [SAMPLE_W-1:0]     sample_two
);

    logic       tick_xfer;
    logic       res_xfer;
    logic [2:0] inflight_reg;

    assign tick_xfer = item_valid && item_ready && opcode == OP_TICK;
    assign res_xfer  = result_valid && result_ready;

    // Ticks transferred in whose result has not yet been transferred out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 3'(tick_xfer) - 3'(res_xfer);
        end
    end

    // A result is only shown for a tick that is still owed
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != 3'd0)
        else $error("result shown with no tick outstanding");

    // At most three ticks fit in the pipeline
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd3)
        else $error("more ticks in flight than pipeline stages");

    // An empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 3'd0 |-> item_ready)
        else $error("item refused while no tick is in flight");

    // A stalled result holds its samples
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(sample_one) && $stable(sample_two))
        else $error("stalled result changed");

endmodule

bind dual_wavetable_morph_oscillator_top dwmo_checker u_dwmo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_one   (sample_one),
    .sample_two   (sample_two)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual wavetable morph oscillator testbench
// Loads the whole wave table, then runs directed and random items through the
// item channel under several tuning settings. An item-level predictor
// computes each tick's pair of samples. The monitor compares every result
// transfer against the oldest predicted pair. Both channels idle at random,
// and one long receiver hold backs up the block.
// ----------------------------------------------------------------------------
module testbench;
    import dwmo_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT   = 100;
    localparam int CHUNK_ITEMS    = 71;
    localparam int PHASE_COUNT    = 6;
    // fourth opcode, which the block ignores
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // one item on the input channel
    typedef struct packed {
        logic [OPCODE_W-1:0]     op;
        logic                    sel;
        logic [SAMPLE_W-1:0]     wave;
        logic [TABLE_ADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0]     data;
    } osc_item_t;

    // one result: both voices' samples of a tick
    typedef struct packed {
        logic [SAMPLE_W-1:0] one;
        logic [SAMPLE_W-1:0] two;
    } sample_pair_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [PHASE_W-1:0]      cfg_data = '0;
    logic                    item_valid = 1'b0;
    logic                    item_ready;
    logic [OPCODE_W-1:0]     opcode = '0;
    logic                    osc_select = 1'b0;
    logic [SAMPLE_W-1:0]     wave_value = '0;
    logic [TABLE_ADDR_W-1:0] table_address = '0;
    logic [SAMPLE_W-1:0]     table_data = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [SAMPLE_W-1:0]     sample_one;
    logic [SAMPLE_W-1:0]     sample_two;

    // stimulus and expectations
    osc_item_t    item_backlog [$];
    sample_pair_t samples_due [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           calm_run = 1'b0;
    int           hold_requests = 0;
    logic [SAMPLE_W-1:0] last_wave [2];

    // predictor state
    logic [PHASE_W-1:0]  osc_phase [2];
    logic [SHAPE_W-1:0]  osc_shape [2];
    logic [BLEND_W-1:0]  osc_mix [2];
    logic [SAMPLE_W-1:0] next_value [2];
    logic                next_flag [2];
    logic [PHASE_W-1:0]  tune_word [2];
    logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

    dual_wavetable_morph_oscillator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .osc_select    (osc_select),
        .wave_value    (wave_value),
        .table_address (table_address),
        .table_data    (table_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .sample_one    (sample_one),
        .sample_two    (sample_two)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log short when the block is badly off
        if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: %s", what);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // crossfaded sample of one voice at its current phase
    function automatic logic [SAMPLE_W-1:0] voice_out(input int v);
        logic [INDEX_W-1:0]      idx;
        logic [TABLE_ADDR_W-1:0] addr_a;
        logic [TABLE_ADDR_W-1:0] addr_b;
        logic [SAMPLE_W-1:0]     a;
        logic [SAMPLE_W-1:0]     b;
        logic [31:0]             prod;
        idx    = osc_phase[v][INDEX_LSB +: INDEX_W];
        addr_a = {osc_shape[v], idx};
        addr_b = addr_a + TABLE_ADDR_W'(WAVE_LENGTH);
        a      = wave_mem[addr_a];
        b      = wave_mem[addr_b];
        // 32-bit wrap of the difference gives the signed product's low bits
        prod   = (32'(a) - 32'(b)) * 32'(osc_mix[v]);
        return prod[23:8] + b;
    endfunction

    // load a queued waveform/mix into a voice
    task automatic take_value(input int v);
        logic [7:0] hi;
        hi = next_value[v][15:8];
        if (hi > 8'(WAVE_COUNT - 2))
            hi = 8'(WAVE_COUNT - 2);
        osc_shape[v] = hi[SHAPE_W-1:0];
        osc_mix[v]   = ~next_value[v][7:0];
        next_flag[v] = 1'b0;
    endtask

    task automatic step_voices(input osc_item_t it);
        sample_pair_t pair;
        case (it.op)
            OP_TICK:
            begin
                osc_phase[0] = osc_phase[0] + tune_word[0];
                pair.one     = voice_out(0);
                osc_phase[1] = osc_phase[1] + tune_word[1];
                pair.two     = voice_out(1);
                // voice one's queued value wins when both wait
                if (next_flag[0])
                    take_value(0);
                else if (next_flag[1])
                    take_value(1);
                samples_due.push_back(pair);
            end
            OP_SET_WAVE:
            begin
                if (next_value[it.sel] != it.wave)
                begin
                    next_value[it.sel] = it.wave;
                    next_flag[it.sel]  = 1'b1;
                end
            end
            OP_TABLE_WRITE:
                wave_mem[it.addr] = it.data;
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Item driver
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        osc_item_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap_left   <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                step_voices('{op: opcode, sel: osc_select, wave: wave_value,
                              addr: table_address, data: table_data});
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left   <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (item_backlog.size() > 0)
                begin
                    nxt            = item_backlog.pop_front();
                    opcode        <= nxt.op;
                    osc_select    <= nxt.sel;
                    wave_value    <= nxt.wave;
                    table_address <= nxt.addr;
                    table_data    <= nxt.data;
                    item_valid    <= 1'b1;
                    if (!calm_run && $urandom_range(0, 9) == 0)
                        gap_left <= $urandom_range(1, 13);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus requested long holds
    // ------------------------------------------------------------------
    int hold_left = 0;
    int holds_done = 0;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done   <= holds_done + 1;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!calm_run && $urandom_range(0, 7) == 0)
        begin
            stall_left   <= $urandom_range(0, 12);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_pair_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (samples_due.size() == 0)
                report_mismatch($sformatf("result %h/%h with no tick pending",
                                          sample_one, sample_two));
            else
            begin
                want = samples_due.pop_front();
                if (sample_one !== want.one)
                    report_mismatch($sformatf("sample_one %h, predicted %h",
                                              sample_one, want.one));
                if (sample_two !== want.two)
                    report_mismatch($sformatf("sample_two %h, predicted %h",
                                              sample_two, want.two));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [OPCODE_W-1:0] op, input logic sel,
                              input logic [SAMPLE_W-1:0] wave,
                              input logic [TABLE_ADDR_W-1:0] addr,
                              input logic [SAMPLE_W-1:0] data);
        item_backlog.push_back('{op: op, sel: sel, wave: wave, addr: addr, data: data});
        if (op == OP_SET_WAVE)
            last_wave[sel] = wave;
    endtask

    // tick with random don't-care fields
    task automatic queue_tick();
        queue_item(OP_TICK, 1'($urandom), SAMPLE_W'($urandom),
                   TABLE_ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic queue_set_wave(input logic sel, input logic [SAMPLE_W-1:0] wave);
        queue_item(OP_SET_WAVE, sel, wave, TABLE_ADDR_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic queue_write(input logic [TABLE_ADDR_W-1:0] addr,
                               input logic [SAMPLE_W-1:0] data);
        queue_item(OP_TABLE_WRITE, 1'($urandom), SAMPLE_W'($urandom), addr, data);
    endtask

    task automatic queue_random_items(input int count);
        osc_item_t it;
        int        roll;
        for (int n = 0; n < count; n++)
        begin
            roll    = $urandom_range(0, 99);
            it.sel  = 1'($urandom);
            it.wave = SAMPLE_W'($urandom);
            it.addr = TABLE_ADDR_W'($urandom);
            it.data = SAMPLE_W'($urandom);
            if (roll < 55)
                it.op = OP_TICK;
            else if (roll < 80)
            begin
                it.op = OP_SET_WAVE;
                case ($urandom_range(0, 3))
                    0: it.wave = last_wave[it.sel];    // no-change case
                    1: it.wave = {8'($urandom_range(0, 8)), 8'($urandom)};
                    2: it.wave = {8'($urandom_range(0, 7)),
                                  ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
                    default: ;
                endcase
            end
            else if (roll < 95)
                it.op = OP_TABLE_WRITE;
            else
                it.op = OP_UNUSED;
            queue_item(it.op, it.sel, it.wave, it.addr, it.data);
        end
    endtask

    // wait until the block has nothing left to do
    task automatic wait_for_quiet();
        while (item_backlog.size() != 0 || item_valid || samples_due.size() != 0)
            @(negedge clk);
        // set-wave and table writes may still be in flight
        repeat (8) @(negedge clk);
    endtask

    task automatic write_tuning(input logic [CFG_INDEX_W-1:0] which,
                                input logic [PHASE_W-1:0] value);
        @(posedge clk);
        cfg_we          <= 1'b1;
        cfg_index       <= which;
        cfg_data        <= value;
        tune_word[which] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        // predictor reset state
        for (int v = 0; v < 2; v++)
        begin
            osc_phase[v]  = '0;
            osc_shape[v]  = '0;
            osc_mix[v]    = BLEND_RESET;
            next_value[v] = '0;
            next_flag[v]  = 1'b0;
            tune_word[v]  = TUNE_RESET;
            last_wave[v]  = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every word a tick can reach gets loaded first
        for (int adr = 0; adr < TABLE_DEPTH; adr++)
            queue_write(TABLE_ADDR_W'(adr), SAMPLE_W'($urandom));

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph > 0)
            begin
                wait_for_quiet();
                case (ph)
                    1:
                    begin
                        write_tuning(REG_TUNING_ONE, '0);
                        write_tuning(REG_TUNING_TWO, '1);
                    end
                    2:
                    begin
                        write_tuning(REG_TUNING_ONE, '1);
                        write_tuning(REG_TUNING_TWO, '0);
                    end
                    3:
                    begin
                        write_tuning(REG_TUNING_ONE, $urandom);
                        write_tuning(REG_TUNING_TWO, $urandom);
                    end
                    4:
                    begin
                        // slow sweeps through the waves
                        write_tuning(REG_TUNING_ONE, $urandom_range(1, 32'h0004_0000));
                        write_tuning(REG_TUNING_TWO, $urandom_range(1, 32'h0004_0000));
                    end
                    default:
                    begin
                        write_tuning(REG_TUNING_ONE, TUNE_RESET);
                        write_tuning(REG_TUNING_TWO, TUNE_RESET);
                        calm_run = 1'b1;
                    end
                endcase
                @(negedge clk);
            end

            if (ph == 0)
            begin
                // equal to the reset pending value: no change
                queue_set_wave(1'b1, 16'h0000);
                // full-scale swing between neighboring waves 0 and 1 at sample indexes 1 and 2
                queue_write(12'd1, 16'hFFFF);
                queue_write(12'd513, 16'h0000);
                queue_write(12'd2, 16'h0000);
                queue_write(12'd514, 16'hFFFF);
                queue_write(12'hFFF, 16'hFFFF);
                queue_tick();
                // both voices queued; voice one applies first
                queue_set_wave(1'b0, 16'h00FF);
                queue_set_wave(1'b1, 16'hFF00);
                queue_set_wave(1'b0, 16'h00FF);
                queue_item(OP_UNUSED, 1'($urandom), SAMPLE_W'($urandom),
                           TABLE_ADDR_W'($urandom), SAMPLE_W'($urandom));
                queue_tick();
                queue_tick();
                queue_set_wave(1'b0, 16'h0000);
                queue_set_wave(1'b1, 16'hFF00);
                queue_tick();
                // waveform above the limit saturates; the limit itself does not
                queue_set_wave(1'b0, 16'h07AA);
                queue_set_wave(1'b1, 16'h0655);
                queue_tick();
                queue_tick();
                queue_set_wave(1'b1, 16'hFFFF);
                queue_set_wave(1'b0, 16'h0000);
                queue_tick();
                queue_tick();
            end

            if (ph == 1)
            begin
                // long receiver hold while ticks keep coming
                hold_requests = hold_requests + 1;
                for (int n = 0; n < 20; n++)
                    queue_tick();
            end

            queue_random_items(CHUNK_ITEMS);
            // sender pause until every result is back
            wait_for_quiet();
            queue_random_items(CHUNK_ITEMS);
        end

        wait_for_quiet();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
